// ----- hdl/rbpb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbpb_pkg: shared types and constants of the radial blend-map brush
// Widths of the distance, divider and queue item, register indexes,
// texture select codes and the per-map action codes.
// ----------------------------------------------------------------------------
package rbpb_pkg;

  // Tile geometry.
  localparam int TexelsPerSide = 256;
  localparam int HalfSide      = TexelsPerSide / 2;

  // Arithmetic widths.
  localparam int RadiusW   = 12;                 // brush radius
  localparam int FracBits  = 8;                  // fraction bits of the distance
  localparam int D2W       = 2 * RadiusW;        // squared distance inside the brush
  localparam int DistW     = RadiusW + FracBits; // distance in q8
  localparam int SqrtSteps = DistW;              // one root bit per stage
  localparam int DenW      = RadiusW + FracBits + 1; // 512 * radius
  localparam int QuoBits   = 8;                  // quotient never exceeds a channel
  localparam int ProdW     = DenW + QuoBits;     // channel term times distance
  localparam int NumCh     = 6;                  // rgb of both maps
  localparam int BackStages = 1 + SqrtSteps + 1 + QuoBits;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CENTRE_X = 3'd0,
    REG_CENTRE_Z = 3'd1,
    REG_RADIUS   = 3'd2,
    REG_TEX_SEL  = 3'd3,
    REG_DRAW     = 3'd4
  } reg_idx_e;

  // Texture select codes.
  localparam logic [1:0] TEX_BASE   = 2'd0;
  localparam logic [1:0] TEX_FIRST  = 2'd1;
  localparam logic [1:0] TEX_SECOND = 2'd2;

  // What happens to one map.
  typedef enum logic [1:0] {
    ACT_PASS  = 2'd0,
    ACT_SCALE = 2'd1,
    ACT_RAISE = 2'd2
  } act_e;

  // Classified texel handed from the front end to the back end.
  typedef struct packed {
    logic [D2W-1:0]     d2;
    logic [RadiusW-1:0] radius;
    act_e               act1;
    act_e               act2;
    logic [3:0][7:0]    m1;
    logic [3:0][7:0]    m2;
  } item_t;

endpackage

// ----- hdl/rbpb_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbpb_if: texel and result channels of the blend-map brush
// Valid/ready channels; a beat moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface rbpb_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] tile_centre_x;
  logic signed [15:0] tile_centre_z;
  logic [7:0]        texel_x;
  logic [7:0]        texel_z;
  logic [7:0]        first_red;
  logic [7:0]        first_green;
  logic [7:0]        first_blue;
  logic [7:0]        first_alpha;
  logic [7:0]        second_red;
  logic [7:0]        second_green;
  logic [7:0]        second_blue;
  logic [7:0]        second_alpha;

  modport source (
    output valid, tile_centre_x, tile_centre_z, texel_x, texel_z,
    output first_red, first_green, first_blue, first_alpha,
    output second_red, second_green, second_blue, second_alpha,
    input  ready
  );
  modport sink (
    input  valid, tile_centre_x, tile_centre_z, texel_x, texel_z,
    input  first_red, first_green, first_blue, first_alpha,
    input  second_red, second_green, second_blue, second_alpha,
    output ready
  );
endinterface

interface rbpb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] new_first_red;
  logic [7:0] new_first_green;
  logic [7:0] new_first_blue;
  logic [7:0] new_first_alpha;
  logic [7:0] new_second_red;
  logic [7:0] new_second_green;
  logic [7:0] new_second_blue;
  logic [7:0] new_second_alpha;
  logic       first_touched;
  logic       second_touched;

  modport source (
    output valid, new_first_red, new_first_green, new_first_blue, new_first_alpha,
    output new_second_red, new_second_green, new_second_blue, new_second_alpha,
    output first_touched, second_touched,
    input  ready
  );
  modport sink (
    input  valid, new_first_red, new_first_green, new_first_blue, new_first_alpha,
    input  new_second_red, new_second_green, new_second_blue, new_second_alpha,
    input  first_touched, second_touched,
    output ready
  );
endinterface

// ----- hdl/rbpb_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbpb_front: configuration and texel classification
// Holds the brush registers, finds the texel's offset from the brush centre,
// tests it against the radius and picks the action for each map.
// ----------------------------------------------------------------------------
module rbpb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  rbpb_in_if.sink             in_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output rbpb_pkg::item_t     push_item_o
);

  typedef struct packed {
    logic [rbpb_pkg::RadiusW-1:0] ax;
    logic [rbpb_pkg::RadiusW-1:0] az;
    logic                         near;
    logic [3:0][7:0]              m1;
    logic [3:0][7:0]              m2;
  } pre_t;

  logic [15:0]                  centre_x_q, centre_z_q;
  logic [rbpb_pkg::RadiusW-1:0] radius_q;
  logic [1:0]                   tex_sel_q;
  logic                         draw_q;

  logic [17:0] px, pz, dx, dz, abs_x, abs_z;
  pre_t        pre_d, pre_q;
  logic        pre_v_q;
  logic        take;

  logic [rbpb_pkg::D2W:0]   d2;
  logic [rbpb_pkg::D2W-1:0] rsq;
  logic                     in_brush;
  rbpb_pkg::act_e           act1, act2;

  // Brush registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q <= '0;
      centre_z_q <= '0;
      radius_q   <= rbpb_pkg::RadiusW'(16);
      tex_sel_q  <= rbpb_pkg::TEX_BASE;
      draw_q     <= 1'b1;
    end else if (cfg_we_i) begin
      case (rbpb_pkg::reg_idx_e'(cfg_idx_i))
        rbpb_pkg::REG_CENTRE_X: centre_x_q <= cfg_data_i;
        rbpb_pkg::REG_CENTRE_Z: centre_z_q <= cfg_data_i;
        rbpb_pkg::REG_RADIUS:   radius_q   <= cfg_data_i[rbpb_pkg::RadiusW-1:0];
        rbpb_pkg::REG_TEX_SEL:  tex_sel_q  <= cfg_data_i[1:0];
        rbpb_pkg::REG_DRAW:     draw_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // World offset from the brush centre and its magnitude.
  always_comb begin
    px = {{2{in_i.tile_centre_x[15]}}, in_i.tile_centre_x} - 18'(rbpb_pkg::HalfSide)
         + {10'd0, in_i.texel_x};
    pz = {{2{in_i.tile_centre_z[15]}}, in_i.tile_centre_z} - 18'(rbpb_pkg::HalfSide)
         + {10'd0, in_i.texel_z};
    dx = px - {{2{centre_x_q[15]}}, centre_x_q};
    dz = pz - {{2{centre_z_q[15]}}, centre_z_q};
    abs_x = dx[17] ? (18'd0 - dx) : dx;
    abs_z = dz[17] ? (18'd0 - dz) : dz;
    pre_d.ax   = abs_x[rbpb_pkg::RadiusW-1:0];
    pre_d.az   = abs_z[rbpb_pkg::RadiusW-1:0];
    pre_d.near = (abs_x[17:rbpb_pkg::RadiusW] == '0) && (abs_z[17:rbpb_pkg::RadiusW] == '0);
    pre_d.m1   = {in_i.first_alpha, in_i.first_blue, in_i.first_green, in_i.first_red};
    pre_d.m2   = {in_i.second_alpha, in_i.second_blue, in_i.second_green,
                  in_i.second_red};
  end

  assign take      = !pre_v_q || push_ready_i;
  assign in_i.ready = take;

  // Offset register; refills in the cycle it drains into the queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_v_q <= 1'b0;
    end else if (take) begin
      pre_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && in_i.valid) begin
      pre_q <= pre_d;
    end
  end

  // Radius test and action per map.
  always_comb begin
    d2 = (rbpb_pkg::D2W+1)'(pre_q.ax) * (rbpb_pkg::D2W+1)'(pre_q.ax)
       + (rbpb_pkg::D2W+1)'(pre_q.az) * (rbpb_pkg::D2W+1)'(pre_q.az);
    rsq = rbpb_pkg::D2W'(radius_q) * rbpb_pkg::D2W'(radius_q);
    in_brush = pre_q.near && (d2 < {1'b0, rsq});
    act1 = rbpb_pkg::ACT_PASS;
    act2 = rbpb_pkg::ACT_PASS;
    if (in_brush) begin
      case (tex_sel_q)
        rbpb_pkg::TEX_BASE: begin
          if (draw_q) begin
            act1 = rbpb_pkg::ACT_SCALE;
            act2 = rbpb_pkg::ACT_SCALE;
          end
        end
        rbpb_pkg::TEX_FIRST: begin
          act1 = draw_q ? rbpb_pkg::ACT_RAISE : rbpb_pkg::ACT_SCALE;
          act2 = draw_q ? rbpb_pkg::ACT_SCALE : rbpb_pkg::ACT_PASS;
        end
        rbpb_pkg::TEX_SECOND: begin
          act1 = draw_q ? rbpb_pkg::ACT_SCALE : rbpb_pkg::ACT_PASS;
          act2 = draw_q ? rbpb_pkg::ACT_RAISE : rbpb_pkg::ACT_SCALE;
        end
        default: ;
      endcase
    end
  end

  assign push_valid_o       = pre_v_q;
  assign push_item_o.d2     = d2[rbpb_pkg::D2W-1:0];
  assign push_item_o.radius = radius_q;
  assign push_item_o.act1   = act1;
  assign push_item_o.act2   = act2;
  assign push_item_o.m1     = pre_q.m1;
  assign push_item_o.m2     = pre_q.m2;

endmodule

// ----- hdl/rbpb_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbpb_fifo: two-entry queue between front end and back end
// Lets the classifier keep taking texels while the back end stalls.
// ----------------------------------------------------------------------------
module rbpb_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  rbpb_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output rbpb_pkg::item_t pop_item_o
);

  rbpb_pkg::item_t entry_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_item_o   = entry_q[rd_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= push_item_i;
    end
  end

endmodule

// ----- hdl/rbpb_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbpb_back: distance, scale and raise arithmetic
// Pipelined square root of the squared distance, one multiply per channel,
// an eight-stage restoring divide by 512 * radius, then alpha and output.
// ----------------------------------------------------------------------------
module rbpb_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_o,
  input  rbpb_pkg::item_t pop_item_i,
  rbpb_out_if.source      out_o
);

  localparam int NSt = rbpb_pkg::BackStages;

  typedef struct packed {
    rbpb_pkg::item_t                               item;
    logic [rbpb_pkg::DistW:0]                      rem;
    logic [rbpb_pkg::DistW-1:0]                    root;
    logic [rbpb_pkg::DenW-1:0]                     den;
    logic [rbpb_pkg::NumCh-1:0][rbpb_pkg::ProdW-1:0] num;
    logic [rbpb_pkg::NumCh-1:0][7:0]               quo;
    logic [rbpb_pkg::NumCh-1:0]                    neg;
  } bk_t;

  typedef struct packed {
    logic [rbpb_pkg::ProdW-1:0] num;
    logic                       neg;
  } ch_t;

  typedef struct packed {
    logic [3:0][7:0] n1;
    logic [3:0][7:0] n2;
    logic            t1;
    logic            t2;
  } res_t;

  bk_t            st_q [NSt];
  logic [NSt-1:0] st_v_q;
  res_t           out_q;
  logic           out_v_q;
  logic           adv;

  function automatic bk_t load_stage(rbpb_pkg::item_t it);
    bk_t n;
    n      = '0;
    n.item = it;
    return n;
  endfunction

  // One bit of the integer square root of d2 * 65536.
  function automatic bk_t sqrt_step(bk_t s, int k);
    bk_t                          n;
    logic [2*rbpb_pkg::DistW-1:0] x;
    logic [1:0]                   pr;
    logic [rbpb_pkg::DistW+2:0]   t, trial;
    n     = s;
    x     = {s.item.d2, {(2*rbpb_pkg::FracBits){1'b0}}};
    pr    = x[2*rbpb_pkg::DistW-1-2*k -: 2];
    t     = {s.rem, pr};
    trial = {1'b0, s.root, 2'b01};
    if (t >= trial) begin
      n.rem  = (rbpb_pkg::DistW+1)'(t - trial);
      n.root = {s.root[rbpb_pkg::DistW-2:0], 1'b1};
    end else begin
      n.rem  = t[rbpb_pkg::DistW:0];
      n.root = {s.root[rbpb_pkg::DistW-2:0], 1'b0};
    end
    return n;
  endfunction

  // Dividend of one channel: scale uses c * 2 * dist, raise uses |254 - c| * w.
  function automatic ch_t ch_setup(logic [7:0] c, rbpb_pkg::act_e act,
                                   logic [rbpb_pkg::DistW-1:0] dq8,
                                   logic [rbpb_pkg::DenW-1:0] den);
    ch_t                       r;
    logic [7:0]                a;
    logic [rbpb_pkg::DenW-1:0] b;
    a     = 8'd0;
    b     = '0;
    r.neg = 1'b0;
    case (act)
      rbpb_pkg::ACT_SCALE: begin
        a = c;
        b = {dq8, 1'b0};
      end
      rbpb_pkg::ACT_RAISE: begin
        b = den - rbpb_pkg::DenW'(dq8);
        if (c == 8'd255) begin
          a     = 8'd1;
          r.neg = 1'b1;
        end else begin
          a = 8'd254 - c;
        end
      end
      default: ;
    endcase
    r.num = rbpb_pkg::ProdW'(a) * rbpb_pkg::ProdW'(b);
    return r;
  endfunction

  function automatic bk_t mul_stage(bk_t s);
    bk_t n;
    ch_t c;
    n     = s;
    n.den = {s.item.radius, {(rbpb_pkg::FracBits+1){1'b0}}};
    n.quo = '0;
    for (int i = 0; i < 3; i++) begin
      c = ch_setup(s.item.m1[i], s.item.act1, s.root, n.den);
      n.num[i] = c.num;
      n.neg[i] = c.neg;
      c = ch_setup(s.item.m2[i], s.item.act2, s.root, n.den);
      n.num[i+3] = c.num;
      n.neg[i+3] = c.neg;
    end
    return n;
  endfunction

  // One quotient bit for every channel.
  function automatic bk_t div_step(bk_t s, int i);
    bk_t                        n;
    logic [rbpb_pkg::ProdW-1:0] dd;
    int                         sh;
    n  = s;
    sh = rbpb_pkg::QuoBits - 1 - i;
    dd = rbpb_pkg::ProdW'(s.den) << sh;
    for (int c = 0; c < rbpb_pkg::NumCh; c++) begin
      if (s.num[c] >= dd) begin
        n.num[c]     = s.num[c] - dd;
        n.quo[c][sh] = 1'b1;
      end
    end
    return n;
  endfunction

  // New channels of one map; alpha is the mean of rgb when the map changed.
  function automatic logic [3:0][7:0] fin_map(logic [3:0][7:0] m, rbpb_pkg::act_e act,
                                              logic [2:0][7:0] q, logic [2:0] neg);
    logic [3:0][7:0] n;
    logic [8:0]      up;
    logic [9:0]      sum;
    logic [19:0]     prod;
    n = m;
    for (int i = 0; i < 3; i++) begin
      up = {1'b0, m[i]} + {1'b0, q[i]};
      case (act)
        rbpb_pkg::ACT_SCALE: n[i] = q[i];
        rbpb_pkg::ACT_RAISE: n[i] = neg[i] ? (8'd255 - q[i]) : up[7:0];
        default:             n[i] = m[i];
      endcase
    end
    sum  = {2'b0, n[0]} + {2'b0, n[1]} + {2'b0, n[2]};
    // Divide by three: 683 / 2048 is exact after flooring for sums up to 765.
    prod = 20'(sum) * 20'd683;
    if (act != rbpb_pkg::ACT_PASS) begin
      n[3] = prod[18:11];
    end
    return n;
  endfunction

  function automatic res_t finish(bk_t s);
    res_t r;
    r.n1 = fin_map(s.item.m1, s.item.act1, s.quo[2:0], s.neg[2:0]);
    r.n2 = fin_map(s.item.m2, s.item.act2, s.quo[5:3], s.neg[5:3]);
    r.t1 = (s.item.act1 != rbpb_pkg::ACT_PASS);
    r.t2 = (s.item.act2 != rbpb_pkg::ACT_PASS);
    return r;
  endfunction

  // The whole pipeline moves when the output register is free or drains.
  assign adv   = !out_v_q || out_o.ready;
  assign pop_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q  <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      st_v_q  <= {st_v_q[NSt-2:0], pop_valid_i};
      out_v_q <= st_v_q[NSt-1];
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0] <= load_stage(pop_item_i);
      for (int k = 0; k < rbpb_pkg::SqrtSteps; k++) begin
        st_q[k+1] <= sqrt_step(st_q[k], k);
      end
      st_q[rbpb_pkg::SqrtSteps+1] <= mul_stage(st_q[rbpb_pkg::SqrtSteps]);
      for (int i = 0; i < rbpb_pkg::QuoBits; i++) begin
        st_q[rbpb_pkg::SqrtSteps+2+i] <= div_step(st_q[rbpb_pkg::SqrtSteps+1+i], i);
      end
      out_q <= finish(st_q[NSt-1]);
    end
  end

  assign out_o.valid            = out_v_q;
  assign out_o.new_first_red    = out_q.n1[0];
  assign out_o.new_first_green  = out_q.n1[1];
  assign out_o.new_first_blue   = out_q.n1[2];
  assign out_o.new_first_alpha  = out_q.n1[3];
  assign out_o.new_second_red   = out_q.n2[0];
  assign out_o.new_second_green = out_q.n2[1];
  assign out_o.new_second_blue  = out_q.n2[2];
  assign out_o.new_second_alpha = out_q.n2[3];
  assign out_o.first_touched    = out_q.t1;
  assign out_o.second_touched   = out_q.t2;

endmodule

// ----- hdl/radial_blendmap_paint_brush_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_blendmap_paint_brush_top: radial blend-map paint brush
// Takes one texel of two RGBA blend maps a clock, unless back-pressure from
// the output fills the queue, and returns it painted or erased by a round
// brush. It returns one result beat per texel, in order. A texel passes the
// offset and classification register, the queue, a load stage, a 20-stage
// square-root pipeline (one root bit per stage), one multiply stage and an
// 8-stage divider, after which the result sits in the output register. A
// two-entry queue sits between the classifier and the arithmetic.
// Configuration writes must be made while no texel is in flight.
// ----------------------------------------------------------------------------
module radial_blendmap_paint_brush_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  rbpb_in_if.sink     in_i,
  rbpb_out_if.source  out_o
);

  logic            push_valid, push_ready, pop_valid, pop;
  rbpb_pkg::item_t push_item, pop_item;

  // Classifier.
  rbpb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  // Decoupling queue.
  rbpb_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_item_o   (pop_item)
  );

  // Arithmetic back end.
  rbpb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_item_i  (pop_item),
    .out_o       (out_o)
  );

endmodule
